/* design/rbs_pkg.sv */
// Shared types for the record bubble sorter.
// Holds the record layout and the emit control bundle; no dependencies.
package rbs_pkg;

    localparam int unsigned REC_W = 48;

    // One stored record, cost in the low bits
    typedef struct packed {
        logic [15:0] code;
        logic [7:0]  carriage;
        logic [7:0]  seat;
        logic [15:0] cost;
    } record_t;

    // Sequencer to output stage: load the RAM read data as a result
    typedef struct packed {
        logic load;
        logic last;
        logic truncated;
    } emit_ctl_t;

endpackage

/* design/rbs_ifs.sv */
// Valid/ready channel interfaces for records in and sorted results out.
// Stand-alone; used by the top level ports.
interface rbs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] rec_code;
    logic [7:0]  rec_carriage;
    logic [7:0]  rec_seat;
    logic [15:0] rec_cost;
    logic        rec_last;

    modport source (output valid, rec_code, rec_carriage, rec_seat, rec_cost, rec_last,
                    input ready);
    modport sink (input valid, rec_code, rec_carriage, rec_seat, rec_cost, rec_last,
                  output ready);
endinterface

interface rbs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_code;
    logic [7:0]  out_carriage;
    logic [7:0]  out_seat;
    logic [15:0] out_cost;
    logic        out_last;
    logic        out_truncated;

    modport source (output valid, out_code, out_carriage, out_seat, out_cost, out_last,
                    out_truncated, input ready);
    modport sink (input valid, out_code, out_carriage, out_seat, out_cost, out_last,
                  out_truncated, output ready);
endinterface

/* design/record_bubble_sort_by_key.sv */
// Top level of the record sorter: channels, record RAM, sequencer, output register.
// Depends on rbs_pkg, rbs_ifs, rbs_ram and rbs_seq.
//
// Records stream in at one per cycle and are written to a DEPTH-entry RAM; the
// record marked last closes the batch (records past DEPTH are dropped and the
// whole batch is flagged truncated). The batch is then bubble-sorted in place by
// ascending cost, stable for equal costs, stopping after a pass without a swap.
// A pass reads one record per cycle from the registered RAM read port and ends
// with a write of the carried record; at most n - 1 passes run for a batch of n.
// Results leave one at a time, each read issued once the previous result is
// loaded and the output register is free. No input is taken from batch close
// until the last result is loaded into the output register.
module record_bubble_sort_by_key #(
    parameter int unsigned DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rbs_in_if.sink    rec,
    rbs_out_if.source res
);
    import rbs_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    record_t         in_rec;
    record_t         ram_wdata;
    record_t         ram_rdata;
    logic [REC_W-1:0] ram_rdata_raw;
    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    emit_ctl_t       emit;
    logic            out_free;

    logic            out_valid_reg;
    record_t         out_rec_reg;
    logic            out_last_reg;
    logic            out_trunc_reg;

    assign in_rec.code     = rec.rec_code;
    assign in_rec.carriage = rec.rec_carriage;
    assign in_rec.seat     = rec.rec_seat;
    assign in_rec.cost     = rec.rec_cost;
    assign ram_rdata       = record_t'(ram_rdata_raw);

    // Record store
    rbs_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    // Load, sort and emit control
    rbs_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rec.valid),
        .in_ready  (rec.ready),
        .in_rec    (in_rec),
        .in_last   (rec.rec_last),
        .out_free  (out_free),
        .emit      (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_rec_reg   <= ram_rdata;
            out_last_reg  <= emit.last;
            out_trunc_reg <= emit.truncated;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.out_code      = out_rec_reg.code;
    assign res.out_carriage  = out_rec_reg.carriage;
    assign res.out_seat      = out_rec_reg.seat;
    assign res.out_cost      = out_rec_reg.cost;
    assign res.out_last      = out_last_reg;
    assign res.out_truncated = out_trunc_reg;

`ifndef SYNTHESIS
    // a result is never loaded over one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> (!out_valid_reg || res.ready))
        else $error("result loaded over a pending result");

    // read-ahead never hits the entry being written back
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write collide on one entry");

    // the final result of a batch ends emission
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit.load && emit.last) |=> !emit.load)
        else $error("result loaded after the last of a batch");

    // no record is taken in a cycle that loads a result
    assert property (@(posedge clk) disable iff (!rst_n)
        emit.load |-> !rec.ready)
        else $error("input ready during emission");
`endif

endmodule

/* design/rbs_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rbs_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/rbs_seq.sv */
// Load / sort / emit sequencer working on the record RAM.
// Depends on rbs_pkg; drives the RAM ports of rbs_ram.
module rbs_seq #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  rbs_pkg::record_t         in_rec,
    input  logic                     in_last,
    input  logic                     out_free,
    output rbs_pkg::emit_ctl_t       emit,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output rbs_pkg::record_t         ram_wdata,
    output logic                     ram_re,
    output logic [$clog2(DEPTH)-1:0] ram_raddr,
    input  rbs_pkg::record_t         ram_rdata
);
    import rbs_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_LOAD,
        S_PASS,
        S_FLUSH,
        S_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] batch_n_reg, batch_n_next;
    logic          trunc_reg, trunc_next;
    logic [CW-1:0] pass_len_reg, pass_len_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] data_idx_reg, data_idx_next;
    record_t       hold_reg, hold_next;
    logic          moved_reg, moved_next;

    logic [CW-1:0] cnt_after;
    logic          ovf_after;
    logic [CW-1:0] pass_end;

    assign in_ready = (state_reg == S_LOAD);
    assign pass_end = pass_len_reg - CW'(1);

    // Next-state and RAM access decode
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        batch_n_next  = batch_n_reg;
        trunc_next    = trunc_reg;
        pass_len_next = pass_len_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        data_idx_next = data_idx_reg;
        hold_next     = hold_reg;
        moved_next    = moved_reg;
        cnt_after     = count_reg;
        ovf_after     = ovf_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[AW-1:0];
        ram_wdata     = in_rec;
        ram_re        = 1'b0;
        ram_raddr     = rd_idx_reg[AW-1:0];
        emit          = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    // store while room is left, else note the drop
                    if (count_reg < FULL)
                    begin
                        ram_we    = 1'b1;
                        cnt_after = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_after = 1'b1;
                    end
                    count_next = cnt_after;
                    ovf_next   = ovf_after;
                    if (in_last)
                    begin
                        batch_n_next  = cnt_after;
                        trunc_next    = ovf_after;
                        pass_len_next = cnt_after;
                        count_next    = '0;
                        ovf_next      = 1'b0;
                        rd_idx_next   = '0;
                        moved_next    = 1'b0;
                        state_next    = (cnt_after >= CW'(2)) ? S_PASS : S_EMIT;
                    end
                end
            end

            S_PASS:
            begin
                // stream reads ahead of the write-back
                if (rd_idx_reg < pass_len_reg)
                begin
                    ram_re        = 1'b1;
                    rd_idx_next   = rd_idx_reg + CW'(1);
                    pend_next     = 1'b1;
                    data_idx_next = rd_idx_reg[AW-1:0];
                end
                // carry the larger record forward, write back the smaller
                if (pend_reg)
                begin
                    if (data_idx_reg != '0)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = data_idx_reg - AW'(1);
                        if (hold_reg.cost > ram_rdata.cost)
                        begin
                            ram_wdata  = ram_rdata;
                            moved_next = 1'b1;
                        end
                        else
                        begin
                            ram_wdata = hold_reg;
                            hold_next = ram_rdata;
                        end
                    end
                    else
                    begin
                        hold_next = ram_rdata;
                    end
                    if (CW'(data_idx_reg) == pass_end)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                // carried record lands at the end of the pass
                ram_we      = 1'b1;
                ram_waddr   = pass_end[AW-1:0];
                ram_wdata   = hold_reg;
                rd_idx_next = '0;
                if (moved_reg && (pass_end >= CW'(2)))
                begin
                    pass_len_next = pass_end;
                    moved_next    = 1'b0;
                    state_next    = S_PASS;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                // one read per result once the output register frees up
                if (!pend_reg && (rd_idx_reg < batch_n_reg) && out_free)
                begin
                    ram_re      = 1'b1;
                    rd_idx_next = rd_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                if (pend_reg)
                begin
                    emit.load      = 1'b1;
                    emit.last      = (rd_idx_reg == batch_n_reg);
                    emit.truncated = trunc_reg;
                    if (rd_idx_reg == batch_n_reg)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            batch_n_reg  <= '0;
            trunc_reg    <= 1'b0;
            pass_len_reg <= '0;
            rd_idx_reg   <= '0;
            pend_reg     <= 1'b0;
            data_idx_reg <= '0;
            moved_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            batch_n_reg  <= batch_n_next;
            trunc_reg    <= trunc_next;
            pass_len_reg <= pass_len_next;
            rd_idx_reg   <= rd_idx_next;
            pend_reg     <= pend_next;
            data_idx_reg <= data_idx_next;
            moved_reg    <= moved_next;
        end
    end

    // Carried record, payload only
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

/* test/record_bubble_sort_by_key_tb.sv */
// Self-checking testbench for record_bubble_sort_by_key: random record batches in,
// sorted results checked against a stable-sort predictor held in a scoreboard class.
// Depends on rbs_pkg, rbs_ifs and the design top level.
module record_bubble_sort_by_key_tb;
    import rbs_pkg::*;

    localparam int unsigned SORT_DEPTH  = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned ITEM_TARGET = 410;

    // Cost patterns used to shape a random batch
    typedef enum int unsigned {
        COST_ANY,
        COST_TIES,
        COST_RISING,
        COST_FALLING
    } cost_mode_t;

    // One expected or observed result
    typedef struct packed {
        record_t rec;
        logic    last;
        logic    truncated;
    } sorted_result_t;

    // Predicts each batch close and checks results in arrival order
    class sort_scoreboard;
        record_t        held[SORT_DEPTH];
        int unsigned    held_count;
        bit             dropped;
        sorted_result_t sorted_due[$];
        int unsigned    errors;

        function new();
            held_count = 0;
            dropped    = 0;
            errors     = 0;
        endfunction

        function int unsigned results_due();
            return sorted_due.size();
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s got %h want %h", what, got, want);
        endtask

        // Store the request; on batch close, sort stably by cost and queue results
        function void take_record(record_t r, logic last);
            record_t        hold;
            sorted_result_t res;
            bit             swapped;
            int             p;
            int             k;
            if (held_count < SORT_DEPTH)
            begin
                held[held_count] = r;
                held_count++;
            end
            else
            begin
                dropped = 1'b1;
            end
            if (!last)
                return;
            swapped = 1'b1;
            for (p = 0; p < int'(held_count) - 1 && swapped; p++)
            begin
                swapped = 1'b0;
                for (k = 0; k + 1 < int'(held_count) - p; k++)
                begin
                    if (held[k].cost > held[k + 1].cost)
                    begin
                        hold        = held[k];
                        held[k]     = held[k + 1];
                        held[k + 1] = hold;
                        swapped     = 1'b1;
                    end
                end
            end
            for (k = 0; k < int'(held_count); k++)
            begin
                res.rec       = held[k];
                res.last      = (k + 1 == int'(held_count));
                res.truncated = dropped;
                sorted_due.push_back(res);
            end
            held_count = 0;
            dropped    = 1'b0;
        endfunction

        task check_sorted(sorted_result_t got);
            sorted_result_t want;
            if (sorted_due.size() == 0)
            begin
                report_mismatch("result with nothing expected, code", got.rec.code, '0);
                return;
            end
            want = sorted_due.pop_front();
            if (got.rec.code !== want.rec.code)
                report_mismatch("code", got.rec.code, want.rec.code);
            if (got.rec.carriage !== want.rec.carriage)
                report_mismatch("carriage", 16'(got.rec.carriage), 16'(want.rec.carriage));
            if (got.rec.seat !== want.rec.seat)
                report_mismatch("seat", 16'(got.rec.seat), 16'(want.rec.seat));
            if (got.rec.cost !== want.rec.cost)
                report_mismatch("cost", got.rec.cost, want.rec.cost);
            if (got.last !== want.last)
                report_mismatch("last", 16'(got.last), 16'(want.last));
            if (got.truncated !== want.truncated)
                report_mismatch("truncated", 16'(got.truncated), 16'(want.truncated));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    bit          steady = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned res_stall = 0;
    int unsigned res_gap;

    sort_scoreboard sb = new();

    rbs_in_if  rec_ch ();
    rbs_out_if res_ch ();

    record_bubble_sort_by_key #(
        .DEPTH (SORT_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec_ch),
        .res   (res_ch)
    );

    initial forever #5 clk = ~clk;

    // Mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            res_stall    <= 0;
        end
        else if (res_stall != 0)
        begin
            res_stall    <= res_stall - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_gap = steady ? 0 : pick_gap();
            if (res_gap == 0)
            begin
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b0;
                res_stall    <= res_gap - 1;
            end
        end
    end

    // Monitor both channels
    always @(posedge clk)
    begin
        if (rst_n && rec_ch.valid && rec_ch.ready)
            sb.take_record({rec_ch.rec_code, rec_ch.rec_carriage, rec_ch.rec_seat,
                            rec_ch.rec_cost}, rec_ch.rec_last);
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_sorted({res_ch.out_code, res_ch.out_carriage, res_ch.out_seat,
                             res_ch.out_cost, res_ch.out_last, res_ch.out_truncated});
    end

    // One request, after an optional gap; valid stays high when there is no gap
    task automatic send_record(input logic [15:0] code, input logic [7:0] carriage,
                               input logic [7:0] seat, input logic [15:0] cost,
                               input logic last);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0)
        begin
            rec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rec_ch.valid        <= 1'b1;
        rec_ch.rec_code     <= code;
        rec_ch.rec_carriage <= carriage;
        rec_ch.rec_seat     <= seat;
        rec_ch.rec_cost     <= cost;
        rec_ch.rec_last     <= last;
        do @(posedge clk); while (!rec_ch.ready);
        items_sent++;
    endtask

    task automatic send_batch(input int unsigned n, input cost_mode_t mode);
        logic [15:0] cost;
        int unsigned i;
        cost = (mode == COST_FALLING) ? 16'($urandom_range(16'h8000, 16'hFFFF))
                                      : 16'($urandom_range(0, 16'h7FFF));
        for (i = 0; i < n; i++)
        begin
            case (mode)
                COST_TIES:    cost = 16'($urandom_range(0, 3));
                COST_RISING:  cost = cost + 16'($urandom_range(0, 300));
                COST_FALLING: cost = cost - 16'($urandom_range(0, 300));
                default:      cost = 16'($urandom);
            endcase
            send_record(16'($urandom), 8'($urandom), 8'($urandom), cost, i + 1 == n);
        end
    endtask

    // Idle the request side, let the monitor note the last request, then wait
    task automatic wait_for_drain();
        rec_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.results_due() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int unsigned batches;
        int unsigned r;
        int unsigned n;
        rst_n               <= 1'b0;
        rec_ch.valid        <= 1'b0;
        rec_ch.rec_code     <= '0;
        rec_ch.rec_carriage <= '0;
        rec_ch.rec_seat     <= '0;
        rec_ch.rec_cost     <= '0;
        rec_ch.rec_last     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single record with every field at its maximum
        send_record(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        // Max then all-zero record: must swap
        send_record(16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 1'b0);
        send_record(16'h0000, 8'h00, 8'h00, 16'h0000, 1'b1);
        // Reverse order, worst case for passes
        send_record(16'h0001, 8'd1, 8'd10, 16'h0400, 1'b0);
        send_record(16'h0002, 8'd2, 8'd20, 16'h0300, 1'b0);
        send_record(16'h0003, 8'd3, 8'd30, 16'h0200, 1'b0);
        send_record(16'h0004, 8'd4, 8'd40, 16'h0100, 1'b1);
        // Equal costs keep arrival order
        send_record(16'h00A1, 8'd7, 8'd1, 16'h0180, 1'b0);
        send_record(16'h00A2, 8'd7, 8'd2, 16'h0180, 1'b0);
        send_record(16'h00A3, 8'd7, 8'd3, 16'h0180, 1'b1);
        // Mixed ties among unequal neighbors
        send_record(16'h00B1, 8'd9, 8'd1, 16'h0005, 1'b0);
        send_record(16'h00B2, 8'd9, 8'd2, 16'h0003, 1'b0);
        send_record(16'h00B3, 8'd9, 8'd3, 16'h0005, 1'b0);
        send_record(16'h00B4, 8'd9, 8'd4, 16'h0003, 1'b0);
        send_record(16'h00B5, 8'd9, 8'd5, 16'h0001, 1'b1);

        // Random batches, mostly small; some full and some overflowing
        batches = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 99) < 15);
            r = $urandom_range(0, 99);
            if (r < 55)
                n = $urandom_range(1, 5);
            else if (r < 80)
                n = $urandom_range(6, 15);
            else if (r < 88)
                n = SORT_DEPTH;
            else if (r < 94)
                n = SORT_DEPTH + 1;
            else
                n = $urandom_range(SORT_DEPTH + 2, SORT_DEPTH + 8);
            // At batch ten and at random, the sender holds off until the sorter has drained
            if (batches == 10 || $urandom_range(0, 99) < 10)
                wait_for_drain();
            send_batch(n, cost_mode_t'($urandom_range(0, 3)));
            batches++;
        end
        rec_ch.valid <= 1'b0;
        steady = 1'b0;

        wait_for_drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.results_due() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* record_bubble_sort_by_key.f */
design/rbs_pkg.sv
design/rbs_ifs.sv
design/rbs_ram.sv
design/rbs_seq.sv
design/record_bubble_sort_by_key.sv
test/record_bubble_sort_by_key_tb.sv
